>>> rtl/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic compare;
        logic update;
        logic any_hit;
        logic insert;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/lrukv_cell.sv
// One cell of the recency-ordered chain: holds one entry and compares it against the request key.
`timescale 1ns / 1ps
`default_nettype none

module lrukv_cell (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire lrukv_pkg::cell_ctrl_t        ctrl,
    input  wire  [lrukv_pkg::KEY_W-1:0]       req_key,
    input  wire lrukv_pkg::entry_t            prev,
    input  wire                               shift_in,
    input  wire                               keep,
    output lrukv_pkg::entry_t                 entry,
    output logic                              shift_out,
    output logic                              match,
    output logic [lrukv_pkg::VAL_W-1:0]       hit_data
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lrukv_pkg::KEY_W-1:0]   key_reg;
    logic [lrukv_pkg::KEY_W-1:0]   key_next;
    logic [lrukv_pkg::VAL_W-1:0]   value_reg;
    logic [lrukv_pkg::VAL_W-1:0]   value_next;
    logic                          match_reg;
    logic                          shift_en;

    assign match     = valid_reg && (key_reg == req_key);
    assign hit_data  = match ? value_reg : '0;
    assign shift_out = match_reg | shift_in;
    assign shift_en  = ctrl.update & (ctrl.any_hit ? shift_out : ctrl.insert);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (shift_en)
        begin
            valid_next = prev.valid & (ctrl.any_hit | keep);
            key_next   = prev.key;
            value_next = prev.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.compare)
            begin
                match_reg <= match;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request control, result register and the cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement, built as a chain
// of ENTRIES cells kept in recency order, the most recent entry in the first cell. Each
// request passes through a compare cycle, in which every cell compares its key with the
// request key and, for a get, the result register is loaded, and then a shift cycle, in
// which the chain shifts the touched or new entry to the front. A new request is taken in
// the shift cycle. A get stays in the compare cycle while the previous result has not been
// taken. A put returns no result. The capacity register may be written only while idle.

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [lrukv_pkg::CAP_W-1:0]         cfg_wdata,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 cmd,
    input  wire  signed [lrukv_pkg::KEY_W-1:0]  lookup_key,
    input  wire  signed [lrukv_pkg::VAL_W-1:0]  store_value,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                hit,
    output logic signed [lrukv_pkg::VAL_W-1:0]  read_value
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CW    = (OCC_W > lrukv_pkg::CAP_W) ? OCC_W : lrukv_pkg::CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t                         state_reg;
    logic                           out_valid_reg;
    logic                           hit_reg;
    logic [lrukv_pkg::VAL_W-1:0]    read_value_reg;
    logic                           any_hit_reg;
    logic [lrukv_pkg::VAL_W-1:0]    hit_value_reg;
    logic [OCC_W-1:0]               occ_reg;
    logic [lrukv_pkg::CAP_W-1:0]    cap_reg;

    logic                           req_cmd_reg;
    logic [lrukv_pkg::KEY_W-1:0]    req_key_reg;
    logic [lrukv_pkg::VAL_W-1:0]    req_value_reg;

    logic                           accept;
    logic                           out_free;
    logic                           cmp_stall;
    logic                           load_result;
    logic [CW-1:0]                  cap_eff;
    logic                           at_cap;
    logic                           insert;
    logic [OCC_W-1:0]               occ_next;
    logic                           any_lookup;
    logic [lrukv_pkg::VAL_W-1:0]    lookup_value;
    lrukv_pkg::cell_ctrl_t          ctrl;
    lrukv_pkg::entry_t              head;

    lrukv_pkg::entry_t              cell_q   [ENTRIES];
    logic [lrukv_pkg::VAL_W-1:0]    contrib  [ENTRIES];
    logic [ENTRIES-1:0]             match_vec;
    logic [ENTRIES-1:0]             shift_vec;
    logic [ENTRIES-1:0]             keep_vec;
    logic [ENTRIES-1:0]             valid_vec;

    assign in_ready   = (state_reg != S_CMP);
    assign accept     = in_valid & in_ready;
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    assign out_free    = !out_valid_reg || out_ready;
    assign cmp_stall   = (req_cmd_reg == lrukv_pkg::CMD_GET) && !out_free;
    assign load_result = (state_reg == S_CMP) && !cmp_stall
                         && (req_cmd_reg == lrukv_pkg::CMD_GET);

    assign cap_eff = (CW'(cap_reg) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_reg);
    assign at_cap  = CW'(occ_reg) >= cap_eff;
    assign insert  = (req_cmd_reg == lrukv_pkg::CMD_PUT) && !any_hit_reg
                     && ((occ_reg != '0) || (cap_eff != '0));
    assign occ_next = (insert && !at_cap) ? occ_reg + OCC_W'(1) : occ_reg;

    assign any_lookup = |match_vec;

    always_comb
    begin
        lookup_value = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            lookup_value = lookup_value | contrib[k];
        end
    end

    assign ctrl.compare = (state_reg == S_CMP);
    assign ctrl.update  = (state_reg == S_UPD);
    assign ctrl.any_hit = any_hit_reg;
    assign ctrl.insert  = insert;

    assign head.valid = 1'b1;
    assign head.key   = req_key_reg;
    assign head.value = (req_cmd_reg == lrukv_pkg::CMD_PUT) ? req_value_reg : hit_value_reg;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lrukv_pkg::entry_t prev_entry;
        logic              shift_in;

        if (i == 0)
        begin : g_first
            assign prev_entry = head;
        end
        else
        begin : g_rest
            assign prev_entry = cell_q[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_last
            assign shift_in = 1'b0;
        end
        else
        begin : g_inner
            assign shift_in = shift_vec[i+1];
        end

        assign keep_vec[i]  = (OCC_W'(i) < occ_next);
        assign valid_vec[i] = cell_q[i].valid;

        lrukv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .req_key   (req_key_reg),
            .prev      (prev_entry),
            .shift_in  (shift_in),
            .keep      (keep_vec[i]),
            .entry     (cell_q[i]),
            .shift_out (shift_vec[i]),
            .match     (match_vec[i]),
            .hit_data  (contrib[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            read_value_reg <= '0;
            any_hit_reg    <= 1'b0;
            hit_value_reg  <= '0;
            occ_reg        <= '0;
            cap_reg        <= lrukv_pkg::CAP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (!cmp_stall)
                    begin
                        any_hit_reg   <= any_lookup;
                        hit_value_reg <= lookup_value;
                        if (req_cmd_reg == lrukv_pkg::CMD_GET)
                        begin
                            hit_reg        <= any_lookup;
                            read_value_reg <= any_lookup ? lookup_value : '1;
                        end
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    occ_reg   <= occ_next;
                    state_reg <= accept ? S_CMP : S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_cmd_reg   <= cmd;
            req_key_reg   <= lookup_key;
            req_value_reg <= store_value;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("Occupancy exceeds the number of cells.");

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("Occupancy disagrees with the valid cells.");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + ENTRIES'(1))) == '0)
        else $error("Valid cells are not packed at the front of the chain.");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $onehot0(match_vec))
        else $error("More than one cell holds the request key.");

    a_get_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && cmp_stall) |=> (state_reg == S_CMP && out_valid_reg))
        else $error("A get left the compare cycle while the result register was full.");

endmodule

`default_nettype wire

>>> tb/sv/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache with a request scoreboard and random traffic.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

    localparam int NUM_ENTRIES = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 192;

    localparam logic [lrukv_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [lrukv_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
    localparam logic [lrukv_pkg::KEY_W-1:0] ALL_ONES = 32'hffff_ffff;

    typedef struct {
        logic                        hit;
        logic [lrukv_pkg::VAL_W-1:0] value;
    } read_result_t;

    class cache_mirror;
        logic [lrukv_pkg::KEY_W-1:0] keys[NUM_ENTRIES];
        logic [lrukv_pkg::VAL_W-1:0] values[NUM_ENTRIES];
        bit               used[NUM_ENTRIES];
        int unsigned      rank[NUM_ENTRIES];
        int unsigned      occupancy;
        int unsigned      capacity;
        read_result_t     pending_reads[$];
        int               errors;

        function new();
            foreach (used[i])
            begin
                used[i] = 0;
                rank[i] = 0;
            end
            occupancy = 0;
            capacity = lrukv_pkg::CAP_RESET;
            errors = 0;
        endfunction

        function void accept_request(logic op, logic [lrukv_pkg::KEY_W-1:0] key,
                                     logic [lrukv_pkg::VAL_W-1:0] value);
            int slot;
            int free_slot;
            int unsigned limit;
            int unsigned old_rank;
            read_result_t res;
            limit = (capacity > NUM_ENTRIES) ? NUM_ENTRIES : capacity;
            slot = -1;
            foreach (used[i])
                if (used[i] && keys[i] == key && slot < 0)
                    slot = i;
            if (op == lrukv_pkg::CMD_GET && slot < 0)
            begin
                res.hit = 1'b0;
                res.value = ALL_ONES;
                pending_reads.push_back(res);
                return;
            end
            if (slot >= 0)
            begin
                if (op == lrukv_pkg::CMD_GET)
                begin
                    res.hit = 1'b1;
                    res.value = values[slot];
                    pending_reads.push_back(res);
                end
                else
                    values[slot] = value;
                old_rank = rank[slot];
                foreach (used[i])
                    if (used[i] && rank[i] < old_rank)
                        rank[i]++;
                rank[slot] = 0;
                return;
            end
            if (occupancy >= limit)
            begin
                if (occupancy == 0)
                    return;
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (used[i] && rank[i] == occupancy - 1)
                    begin
                        used[i] = 0;
                        rank[i] = 0;
                        occupancy--;
                        break;
                    end
                end
            end
            free_slot = -1;
            foreach (used[i])
                if (!used[i] && free_slot < 0)
                    free_slot = i;
            if (free_slot < 0)
                return;
            foreach (used[i])
                if (used[i])
                    rank[i]++;
            keys[free_slot] = key;
            values[free_slot] = value;
            used[free_slot] = 1;
            rank[free_slot] = 0;
            occupancy++;
        endfunction

        function void check_read(logic got_hit, logic [lrukv_pkg::VAL_W-1:0] got_value);
            read_result_t want;
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit %0b value %08h",
                         $time, got_hit, got_value);
                errors++;
                return;
            end
            want = pending_reads.pop_front();
            if (got_hit !== want.hit)
            begin
                $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, got_hit);
                errors++;
            end
            if (got_value !== want.value)
            begin
                $display("%0t: read_value mismatch, expected %08h, actual %08h",
                         $time, want.value, got_value);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [lrukv_pkg::CAP_W-1:0]        cfg_wdata;
    logic                               in_valid;
    logic                               in_ready;
    logic                               cmd;
    logic signed [lrukv_pkg::KEY_W-1:0] lookup_key;
    logic signed [lrukv_pkg::VAL_W-1:0] store_value;
    logic                               out_valid;
    logic                               out_ready;
    logic                               hit;
    logic signed [lrukv_pkg::VAL_W-1:0] read_value;

    cache_mirror mirror;
    int          accepted_count = 0;
    int          cycle_count = 0;
    bit          sender_gaps = 0;
    bit          receiver_stalls = 0;
    bit          hold_done = 0;

    lru_key_value_cache #(
        .ENTRIES(NUM_ENTRIES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .lookup_key(lookup_key),
        .store_value(store_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .read_value(read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                mirror.check_read(hit, read_value);
            if (in_valid && in_ready)
            begin
                mirror.accept_request(cmd, lookup_key, store_value);
                accepted_count++;
            end
        end
    end

    // The receiver stalls at random, and once holds off long enough for the cache to back up.
    initial
    begin
        int roll;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            roll = $urandom_range(0, 99);
            if (!hold_done && accepted_count >= HOLD_AFTER)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1;
                out_ready = 1'b1;
            end
            else if (receiver_stalls && roll < 25)
            begin
                out_ready = 1'b0;
                if (roll < 22)
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                else
                    repeat ($urandom_range(10, 40)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
                out_ready = 1'b1;
        end
    end

    task automatic send_request(logic op, logic [lrukv_pkg::KEY_W-1:0] key,
                                logic [lrukv_pkg::VAL_W-1:0] value);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        gap = 0;
        if (sender_gaps && roll >= 70)
            gap = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = op;
        lookup_key = key;
        store_value = value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (mirror.pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lrukv_pkg::CAP_W-1:0] limit);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = limit;
        mirror.capacity = limit;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_random_phase(logic [lrukv_pkg::CAP_W-1:0] limit, int count);
        logic [lrukv_pkg::KEY_W-1:0] key_pool[$];
        logic [lrukv_pkg::KEY_W-1:0] key;
        int                          pool_size;
        write_capacity(limit);
        sender_gaps = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
        pool_size = $urandom_range(1, 24);
        for (int k = 0; k < pool_size; k++)
            key_pool.push_back($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request($urandom_range(0, 1) ? lrukv_pkg::CMD_PUT : lrukv_pkg::CMD_GET,
                         key, $urandom);
        end
        wait_idle();
    endtask

    initial
    begin
        logic [lrukv_pkg::CAP_W-1:0] phase_caps[PHASE_COUNT];
        phase_caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd5, 5'd17, 5'd2, 5'd12, 5'd16, 5'd3};
        mirror = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = lrukv_pkg::CMD_GET;
        lookup_key = '0;
        store_value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A zero capacity on an empty cache stores nothing.
        write_capacity(5'd0);
        send_request(lrukv_pkg::CMD_PUT, 32'h0000_00a5, 32'h5a5a_5a5a);
        send_request(lrukv_pkg::CMD_GET, 32'h0000_00a5, '0);
        wait_idle();

        write_capacity(lrukv_pkg::CAP_RESET);
        send_request(lrukv_pkg::CMD_GET, KEY_MAX, '0);
        send_request(lrukv_pkg::CMD_PUT, KEY_MIN, KEY_MAX);
        send_request(lrukv_pkg::CMD_PUT, KEY_MAX, KEY_MIN);
        send_request(lrukv_pkg::CMD_PUT, ALL_ONES, ALL_ONES);
        send_request(lrukv_pkg::CMD_PUT, '0, '0);
        send_request(lrukv_pkg::CMD_GET, KEY_MIN, ALL_ONES);
        send_request(lrukv_pkg::CMD_GET, ALL_ONES, '0);
        send_request(lrukv_pkg::CMD_GET, '0, ALL_ONES);
        send_request(lrukv_pkg::CMD_PUT, KEY_MIN, 32'h1234_5678);
        send_request(lrukv_pkg::CMD_GET, KEY_MIN, '0);
        send_request(lrukv_pkg::CMD_GET, KEY_MAX, '0);
        send_request(lrukv_pkg::CMD_GET, 32'h0000_0001, '0);
        wait_idle();

        // Lowering the capacity below the occupancy evicts only on later inserts.
        write_capacity(5'd2);
        send_request(lrukv_pkg::CMD_PUT, 32'h0000_0055, 32'hcafe_f00d);
        send_request(lrukv_pkg::CMD_GET, ALL_ONES, '0);
        send_request(lrukv_pkg::CMD_GET, 32'h0000_0055, '0);
        send_request(lrukv_pkg::CMD_PUT, 32'h0000_0066, 32'h0bad_beef);
        send_request(lrukv_pkg::CMD_GET, '0, '0);
        send_request(lrukv_pkg::CMD_GET, KEY_MAX, '0);
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++)
            run_random_phase(phase_caps[p], PHASE_ITEMS);

        if (mirror.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
